// ===== hw/rtl/ptint_pkg.sv =====
// Shared types, constants and the gray step table for the palette tint block.
// No dependencies; every other file of the block imports this package.
package ptint_pkg;

  // Channel and field widths
  localparam int ChW       = 5;
  localparam int ColorW    = 16;
  localparam int ToneW     = 16;
  localparam int CfgIndexW = 4;
  localparam int CfgDataW  = 16;

  // Luma weights in 0.8
  localparam logic [7:0] LumaR = 8'd76;
  localparam logic [7:0] LumaG = 8'd151;
  localparam logic [7:0] LumaB = 8'd29;

  // Sepia multipliers in 8.8
  localparam logic [ToneW-1:0] SepiaR = 16'd307;
  localparam logic [ToneW-1:0] SepiaG = 16'd256;
  localparam logic [ToneW-1:0] SepiaB = 16'd240;

  // Largest channel value
  localparam logic [ChW-1:0] ChMax = 5'h1F;

  // Tone register reset value (1.0 in 8.8)
  localparam logic [ToneW-1:0] ToneOne = 16'd256;

  // Tint modes
  typedef enum logic [1:0] {
    MODE_GRAY    = 2'd0,
    MODE_STEPPED = 2'd1,
    MODE_SEPIA   = 2'd2,
    MODE_CUSTOM  = 2'd3
  } tint_mode_t;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] RegTintMode  = 4'd0;
  localparam logic [CfgIndexW-1:0] RegRedTone   = 4'd1;
  localparam logic [CfgIndexW-1:0] RegGreenTone = 4'd2;
  localparam logic [CfgIndexW-1:0] RegBlueTone  = 4'd3;

  // Current configuration as seen by the datapath
  typedef struct packed {
    tint_mode_t       mode;
    logic [ToneW-1:0] red_tone;
    logic [ToneW-1:0] green_tone;
    logic [ToneW-1:0] blue_tone;
  } cfg_regs_t;

  // One gray value with its side fields, between the luma and tone units
  typedef struct packed {
    logic [ChW-1:0] gray;
    logic           alpha;
    logic           last;
  } gray_item_t;

  // Gray mapped to one of the coarse steps, grouped by fives
  function automatic logic [ChW-1:0] step_lookup(input logic [ChW-1:0] g);
    logic [ChW-1:0] s;
    begin
      if (g < 5'd5) begin
        s = 5'd0;
      end else if (g < 5'd10) begin
        s = 5'd5;
      end else if (g < 5'd15) begin
        s = 5'd11;
      end else if (g < 5'd20) begin
        s = 5'd16;
      end else if (g < 5'd25) begin
        s = 5'd21;
      end else if (g < 5'd30) begin
        s = 5'd27;
      end else begin
        s = 5'd31;
      end
      return s;
    end
  endfunction

  // Take bits 15:8 of a 16-bit product and clamp to the channel range
  function automatic logic [ChW-1:0] clamp_hi(input logic [ToneW-1:0] p);
    begin
      return (p[15:13] != 3'd0) ? ChMax : p[12:8];
    end
  endfunction

endpackage

// ===== hw/rtl/ptint_cfg.sv =====
// Configuration register file for the palette tint block.
// Depends on ptint_pkg for register indexes and the cfg_regs_t type.
module ptint_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptint_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [ptint_pkg::CfgDataW-1:0]     cfg_data,
  output ptint_pkg::cfg_regs_t               regs
);
  import ptint_pkg::*;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode       <= MODE_GRAY;
      regs.red_tone   <= ToneOne;
      regs.green_tone <= ToneOne;
      regs.blue_tone  <= ToneOne;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegTintMode:  regs.mode       <= tint_mode_t'(cfg_data[1:0]);
        RegRedTone:   regs.red_tone   <= cfg_data[ToneW-1:0];
        RegGreenTone: regs.green_tone <= cfg_data[ToneW-1:0];
        RegBlueTone:  regs.blue_tone  <= cfg_data[ToneW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ptint_luma.sv =====
// Two-stage luma unit: weighted channel products, then the sum shifted to gray.
// Depends on ptint_pkg for widths, luma weights and gray_item_t.
module ptint_luma (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ptint_pkg::ColorW-1:0]    color,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ptint_pkg::gray_item_t           out_item
);
  import ptint_pkg::*;

  // Stage A registers: the three weighted channels
  logic        a_valid;
  logic [11:0] a_pr;
  logic [12:0] a_pg;
  logic [9:0]  a_pb;
  logic        a_alpha;
  logic        a_last;
  logic        a_ready;

  // Stage B registers: the gray item
  logic        b_valid;
  logic        b_ready;
  logic [12:0] sum;

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Stage A: constant multiplies of each channel
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_pr    <= 12'(color[4:0] * LumaR);
      a_pg    <= 13'(color[9:5] * LumaG);
      a_pb    <= 10'(color[14:10] * LumaB);
      a_alpha <= color[15];
      a_last  <= last;
    end
  end

  // Stage B: sum of the products, top bits are the gray level
  assign sum = 13'(a_pr) + a_pg + 13'(a_pb);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_item.gray  <= sum[12:8];
      out_item.alpha <= a_alpha;
      out_item.last  <= a_last;
    end
  end

  assign out_valid = b_valid;

endmodule

// ===== hw/rtl/ptint_tone.sv =====
// Two-stage tint unit: per-channel multiply of gray, then clamp and mode select.
// Depends on ptint_pkg for cfg_regs_t, gray_item_t, the step table and clamp.
module ptint_tone (
  input  logic                            clk,
  input  logic                            rst,
  input  ptint_pkg::cfg_regs_t            regs,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ptint_pkg::gray_item_t           in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ptint_pkg::ColorW-1:0]    color,
  output logic                            last
);
  import ptint_pkg::*;

  // Stage C registers: products wrapped to 16 bits
  logic             c_valid;
  logic             c_ready;
  logic [ToneW-1:0] c_pr;
  logic [ToneW-1:0] c_pg;
  logic [ToneW-1:0] c_pb;
  gray_item_t       c_item;

  // Multiplier operands chosen by mode
  logic [ToneW-1:0] mul_r;
  logic [ToneW-1:0] mul_g;
  logic [ToneW-1:0] mul_b;

  // Stage D: output register
  logic             d_valid;
  logic             d_ready;
  logic [ChW-1:0]   ro;
  logic [ChW-1:0]   go;
  logic [ChW-1:0]   bo;
  logic [ChW-1:0]   stepped;

  assign d_ready  = !d_valid || out_ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  // Sepia uses fixed multipliers, custom tone the registers.
  always_comb begin
    if (regs.mode == MODE_SEPIA) begin
      mul_r = SepiaR;
      mul_g = SepiaG;
      mul_b = SepiaB;
    end else begin
      mul_r = regs.red_tone;
      mul_g = regs.green_tone;
      mul_b = regs.blue_tone;
    end
  end

  // Stage C: one 16x5 multiply per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      c_pr   <= 16'(mul_r * in_item.gray);
      c_pg   <= 16'(mul_g * in_item.gray);
      c_pb   <= 16'(mul_b * in_item.gray);
      c_item <= in_item;
    end
  end

  // Stage D: pick the channel values for the active mode
  assign stepped = step_lookup(c_item.gray);

  always_comb begin
    unique case (regs.mode)
      MODE_GRAY: begin
        ro = c_item.gray;
        go = c_item.gray;
        bo = c_item.gray;
      end
      MODE_STEPPED: begin
        ro = stepped;
        go = stepped;
        bo = stepped;
      end
      default: begin
        ro = clamp_hi(c_pr);
        go = clamp_hi(c_pg);
        bo = clamp_hi(c_pb);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      color <= {c_item.alpha, bo, go, ro};
      last  <= c_item.last;
    end
  end

  assign out_valid = d_valid;

endmodule

// ===== hw/rtl/palette_color_tint_core.sv =====
// Palette color tint core: grayscale, stepped gray, sepia or custom tone.
// Depends on ptint_pkg, ptint_cfg, ptint_luma and ptint_tone.
//
// Usage:
//   s_tdata[15:0] carries one RGB555 color (red 4:0, green 9:5, blue 14:10,
//   alpha 15) and s_tlast marks the last entry of a run. Each accepted
//   request gives exactly one result on m_tdata / m_tlast, alpha and last
//   copied from the same entry.
//   The cfg channel writes the mode and the three 8.8 tone registers; it
//   always accepts. Write it only while no item is in flight.
// Stages and throughput:
//   A request passes through registers in order: luma products, gray sum,
//   tone multiply, then clamp and output register. One item per cycle is
//   accepted in steady state while m_tready stays high.
// Reset:
//   rst clears all stage valid bits, sets the mode to plain gray and every
//   tone to 1.0.
// Stalls:
//   When m_tready is low the output holds; each stage still fills while it
//   is empty, so up to four items are held and s_tready drops only when all
//   stages are full.
module palette_color_tint_core (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ptint_pkg::ColorW-1:0]        s_tdata,  // [15:0] color_in
  input  logic                                s_tlast,
  // Output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ptint_pkg::ColorW-1:0]        m_tdata,  // [15:0] color_out
  output logic                                m_tlast,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptint_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [ptint_pkg::CfgDataW-1:0]      cfg_data
);
  import ptint_pkg::*;

  cfg_regs_t  regs;
  gray_item_t gray_item;
  logic       gray_valid;
  logic       gray_ready;

  // Configuration registers
  ptint_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Gray level from the input color
  ptint_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .color     (s_tdata),
    .last      (s_tlast),
    .out_valid (gray_valid),
    .out_ready (gray_ready),
    .out_item  (gray_item)
  );

  // Tinted color from gray
  ptint_tone u_tone (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .in_valid  (gray_valid),
    .in_ready  (gray_ready),
    .in_item   (gray_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .color     (m_tdata),
    .last      (m_tlast)
  );

endmodule

// ===== tb/tb_palette_color_tint_core.sv =====
// Self-checking testbench for palette_color_tint_core: random and directed palette colors
// under every tint mode, with expected colors computed in the bench itself.
// Depends on ptint_pkg and the palette_color_tint_core RTL.
module tb_palette_color_tint_core;
  import ptint_pkg::*;

  // Highest configuration index; everything above RegBlueTone is unmapped
  localparam logic [CfgIndexW-1:0] RegIndexTop = '1;
  localparam int DirectedColors = 5;
  localparam int RandomBatch    = 125;
  localparam int DrainCycles    = 16;
  localparam int QuietLimit     = 4000;

  // One request waiting to be sent; hold_for_drain makes the sender wait
  // until every outstanding result has been returned
  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              last;
    logic              hold_for_drain;
  } palette_req_t;

  // One expected result
  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              last;
  } tinted_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [ColorW-1:0]    s_tdata  = '0;  // [15:0] color_in
  logic                 s_tlast  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [ColorW-1:0]    m_tdata;        // [15:0] color_out
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  // Bench copy of the configuration registers
  tint_mode_t       mode_r  = MODE_GRAY;
  logic [ToneW-1:0] red_r   = ToneOne;
  logic [ToneW-1:0] green_r = ToneOne;
  logic [ToneW-1:0] blue_r  = ToneOne;

  palette_req_t palette_q[$];
  tinted_t      tinted_q[$];
  int           send_idle   = 0;
  int           recv_idle   = 0;
  int           fault_count = 0;
  int           quiet_cycles = 0;

  palette_color_tint_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bits 15:8 of a 16-bit wrapped product, limited to the channel range.
  function automatic logic [ChW-1:0] scaled_channel(input int unsigned prod);
    int unsigned v;
    v = (prod & 32'hFFFF) >> 8;
    return (v > ChMax) ? ChMax : v[ChW-1:0];
  endfunction

  // Coarse gray levels: gray is grouped in fives, the top group is full scale.
  function automatic logic [ChW-1:0] gray_step(input int unsigned gray);
    logic [ChW-1:0] s;
    case (gray / 5)
      0: s = 5'd0;
      1: s = 5'd5;
      2: s = 5'd11;
      3: s = 5'd16;
      4: s = 5'd21;
      5: s = 5'd27;
      default: s = ChMax;
    endcase
    return s;
  endfunction

  // Expected tinted color for one palette entry under the current registers.
  function automatic tinted_t tint_entry(input logic [ColorW-1:0] c, input logic last);
    int unsigned gray;
    logic [ChW-1:0] ro, go, bo;
    tinted_t t;
    gray = (LumaR * int'(c[4:0]) + LumaG * int'(c[9:5]) + LumaB * int'(c[14:10])) >> 8;
    case (mode_r)
      MODE_GRAY: begin
        ro = gray[ChW-1:0];
        go = ro;
        bo = ro;
      end
      MODE_STEPPED: begin
        ro = gray_step(gray);
        go = ro;
        bo = ro;
      end
      MODE_SEPIA: begin
        ro = scaled_channel(SepiaR * gray);
        go = scaled_channel(SepiaG * gray);
        bo = scaled_channel(SepiaB * gray);
      end
      default: begin
        ro = scaled_channel(red_r * gray);
        go = scaled_channel(green_r * gray);
        bo = scaled_channel(blue_r * gray);
      end
    endcase
    t.color = {c[15], bo, go, ro};
    t.last  = last;
    return t;
  endfunction

  // Register write: called at a rising edge, returns at the accepting edge
  // with cfg_valid still high so back-to-back writes need no gap.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      RegTintMode:  mode_r  = tint_mode_t'(val[1:0]);
      RegRedTone:   red_r   = val;
      RegGreenTone: green_r = val;
      RegBlueTone:  blue_r  = val;
      default: ;
    endcase
  endtask

  // Called on a falling edge; returns once every request is sent and answered.
  task automatic wait_drained();
    while (palette_q.size() != 0 || s_tvalid || tinted_q.size() != 0) @(negedge clk);
  endtask

  // Tone values: the extremes and unity often, small gains, else anything.
  function automatic logic [ToneW-1:0] pick_tone();
    logic [ToneW-1:0] v;
    case ($urandom_range(5))
      0: v = '0;
      1: v = '1;
      2: v = ToneOne;
      3, 4: v = ToneW'($urandom_range(16'h0900));
      default: v = ToneW'($urandom_range(16'hFFFF));
    endcase
    return v;
  endfunction

  // Sender: one request register, refilled from palette_q
  always @(posedge clk) begin : sender
    palette_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        tinted_q.push_back(tint_entry(s_tdata, s_tlast));
      end
      if (!s_tvalid || s_tready) begin
        if (palette_q.size() != 0 && $urandom_range(99) >= send_idle &&
            !(palette_q[0].hold_for_drain && tinted_q.size() != 0)) begin
          req = palette_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= req.color;
          s_tlast  <= req.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure and comparison against the oldest expectation
  always @(posedge clk) begin : receiver
    tinted_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (tinted_q.size() == 0) begin
          $error("result with none expected: color_out %h last_out %b", m_tdata, m_tlast);
          fault_count++;
        end else begin
          want = tinted_q.pop_front();
          if (m_tdata !== want.color) begin
            $error("color_out: expected %h, got %h", want.color, m_tdata);
            fault_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last_out: expected %b, got %b", want.last, m_tlast);
            fault_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles without any accepted request, result or register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [ColorW-1:0] probe_color [DirectedColors];
    logic [CfgDataW-1:0] data;
    logic [1:0] mode;
    int grp, ph, sub, i, drain_at;

    // Black, full white with alpha, red with alpha, pure green, mid gray
    probe_color[0] = 16'h0000;
    probe_color[1] = 16'hFFFF;
    probe_color[2] = 16'h801F;
    probe_color[3] = 16'h03E0;
    probe_color[4] = 16'h294A;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset values first, then every mode, wide mode writes,
    // tone extremes and a write to an unmapped index
    send_idle = 33;
    recv_idle = 71;
    for (grp = 0; grp < 5; grp++) begin
      @(posedge clk);
      case (grp)
        1: write_reg(RegTintMode, 16'hFFFF);
        2: write_reg(RegTintMode, 16'h5555);
        3: write_reg(RegTintMode, 16'hAAAA);
        4: begin
          write_reg(RegRedTone, 16'hFFFF);
          write_reg(RegGreenTone, 16'h0000);
          write_reg(RegBlueTone, 16'h0180);
          write_reg(RegIndexTop, 16'h0001);
          write_reg(RegTintMode, 16'hFFFF);
        end
        default: ;
      endcase
      cfg_valid <= 1'b0;
      @(negedge clk);
      for (i = 0; i < DirectedColors; i++) begin
        palette_q.push_back('{probe_color[i], i[0], 1'b0});
      end
      wait_drained();
    end

    // Random part: three backpressure profiles, each over all four modes
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 33;
          recv_idle = 71;
        end
        1: begin
          send_idle = 71;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (sub = 0; sub < 5; sub++) begin
        @(posedge clk);
        if (sub < 4) begin
          mode = 2'(sub);
        end else begin
          mode = 2'($urandom_range(3));
        end
        data = CfgDataW'($urandom_range(16'hFFFF));
        data[1:0] = mode;
        write_reg(RegTintMode, data);
        if ($urandom_range(2) != 0) write_reg(RegRedTone, pick_tone());
        if ($urandom_range(2) != 0) write_reg(RegGreenTone, pick_tone());
        if ($urandom_range(2) != 0) write_reg(RegBlueTone, pick_tone());
        if ($urandom_range(1) != 0) begin
          write_reg(RegIndexTop - CfgIndexW'($urandom_range(11)),
                    CfgDataW'($urandom_range(16'hFFFF)));
        end
        cfg_valid <= 1'b0;
        @(negedge clk);
        drain_at = $urandom_range(RandomBatch - 1);
        for (i = 0; i < RandomBatch; i++) begin
          palette_q.push_back('{ColorW'($urandom_range(16'hFFFF)), $urandom_range(7) == 0,
                                i == drain_at});
        end
        wait_drained();
      end
    end

    // Let any stray result show up before the verdict
    repeat (DrainCycles) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ptint_pkg.sv
hw/rtl/ptint_cfg.sv
hw/rtl/ptint_luma.sv
hw/rtl/ptint_tone.sv
hw/rtl/palette_color_tint_core.sv
tb/tb_palette_color_tint_core.sv
